@@ rtl/cemf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cemf_pkg
// Types and fixed widths shared by the corner E3 stencil controller and
// datapath.
// ----------------------------------------------------------------------------
package cemf_pkg;

   localparam int DATA_W     = 32;   // Q16.16 field width
   localparam int WEIGHT_W   = 17;   // Q1.16 weight, 65536 is one
   localparam int ROW_W      = 11;   // row_width register width

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 17'd65536;
   localparam logic [ROW_W-1:0]    ROW_WIDTH_RESET = 11'd1024;

   // intermediate widths of the corner sum
   localparam int CENTRE_W = 66;    // vx*b2 - vy*b1 + half, exact
   localparam int P_W      = 36;    // weight difference without centred term
   localparam int D_W      = 37;    // full weight difference
   localparam int Q_W      = 37;    // unit-weight sum without centred term
   localparam int B_W      = 38;    // full unit-weight sum
   localparam int PROD_W   = 55;    // weight times difference
   localparam int ACC_W    = 58;    // corner accumulator

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CENTRE,
      ST_WEIGHT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;     // capture an item and read the line buffer
      logic mul;        // form the two centred products
      logic centre;     // round and clamp the centred E3
      logic weight;     // weighted products, line and neighbour update
      logic out_load;   // load the corner result into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic emit;       // current item yields a corner result
      logic out_full;   // output register holds an item not yet taken
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/cemf_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cemf_ctrl
// Sequencer for the corner E3 stencil: steps each item through product,
// centre, weight and finish, and gates the input and output handshakes.
// ----------------------------------------------------------------------------
module cemf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   rsp_ready,
   input  wire cemf_pkg::dp_status_type status,
   output cemf_pkg::dp_cmd_type        cmd
);

   cemf_pkg::state_type state_ff, state_in;
   logic can_finish;

   // the finish step may proceed unless a result is due and the slot is blocked
   assign can_finish = !status.emit || !status.out_full || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cemf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cemf_pkg::ST_IDLE: begin
            if (req_valid) state_in = cemf_pkg::ST_MUL;
         end
         cemf_pkg::ST_MUL:    state_in = cemf_pkg::ST_CENTRE;
         cemf_pkg::ST_CENTRE: state_in = cemf_pkg::ST_WEIGHT;
         cemf_pkg::ST_WEIGHT: state_in = cemf_pkg::ST_FINISH;
         cemf_pkg::ST_FINISH: begin
            if (can_finish) begin
               state_in = req_valid ? cemf_pkg::ST_MUL : cemf_pkg::ST_IDLE;
            end
         end
         default: state_in = cemf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         cemf_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         cemf_pkg::ST_MUL:    cmd.mul    = 1'b1;
         cemf_pkg::ST_CENTRE: cmd.centre = 1'b1;
         cemf_pkg::ST_WEIGHT: cmd.weight = 1'b1;
         cemf_pkg::ST_FINISH: begin
            req_ready    = can_finish;
            cmd.out_load = can_finish && status.emit;
            cmd.accept   = can_finish && req_valid;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/cemf_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cemf_dp
// Datapath of the corner E3 stencil: operand registers, line buffer,
// neighbour registers, raster position, multipliers and output register.
// ----------------------------------------------------------------------------
module cemf_dp #(
   parameter int MAX_ROW = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cemf_pkg::dp_cmd_type                  cmd,
   output cemf_pkg::dp_status_type                    status,
   input  wire logic                                  csr_wr_en,
   input  wire logic        [cemf_pkg::ROW_W-1:0]     csr_wr_data,
   input  wire logic                                  req_start_of_plane,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_velocity_x,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_velocity_y,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_field_b1,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_field_b2,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_face1_e3,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_face2_e3,
   input  wire logic        [cemf_pkg::WEIGHT_W-1:0]  req_weight1,
   input  wire logic        [cemf_pkg::WEIGHT_W-1:0]  req_weight2,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic signed      [cemf_pkg::DATA_W-1:0]    rsp_corner_e3,
   output logic                                       rsp_saturated
);

   localparam int DW     = cemf_pkg::DATA_W;
   localparam int WW     = cemf_pkg::WEIGHT_W;
   localparam int COL_W  = (MAX_ROW > 2) ? $clog2(MAX_ROW) : 1;
   localparam int CNT_W  = $clog2(MAX_ROW + 1);
   localparam int WC_W   = (CNT_W > cemf_pkg::ROW_W) ? CNT_W : cemf_pkg::ROW_W;
   localparam int CW     = cemf_pkg::CENTRE_W;
   localparam int P_W    = cemf_pkg::P_W;
   localparam int D_W    = cemf_pkg::D_W;
   localparam int Q_W    = cemf_pkg::Q_W;
   localparam int B_W    = cemf_pkg::B_W;
   localparam int PROD_W = cemf_pkg::PROD_W;
   localparam int ACC_W  = cemf_pkg::ACC_W;
   localparam int CR_W   = CW - 16;      // centred E3 before clamping
   localparam int AR_W   = ACC_W - 18;   // corner E3 before clamping

   localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};

   // configuration and raster position
   logic [cemf_pkg::ROW_W-1:0] row_width_ff;
   logic [COL_W-1:0]           col_ff;
   logic                       past_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   // item operands
   logic signed [DW-1:0] vx_ff, vy_ff, b1_ff, b2_ff, f1_ff, f2_ff;
   logic        [WW-1:0] w1_ff, w2_ff, w1_in, w2_in;
   logic                 sat_ff, emit_ff;
   logic [COL_W-1:0]     col_item_ff, rd_addr;
   logic                 item_emit;

   // line buffer: centred E3 in the upper half, x1-face E3 in the lower
   logic [2*DW-1:0] line_mem [MAX_ROW];
   logic [2*DW-1:0] line_rd_ff;
   logic signed [DW-1:0] up_rd, f1u_rd;

   // neighbours
   logic signed [DW-1:0] left_centre_ff, left_face2_ff, upper_left_ff;

   // arithmetic
   logic signed [2*DW-1:0]   pa_ff, pb_ff, pa_in, pb_in;
   logic signed [CW-1:0]     centre_sum;
   logic signed [CR_W-1:0]   centre_rnd;
   logic signed [DW-1:0]     cc_ff, cc_in;
   logic                     cc_sat;
   logic signed [P_W-1:0]    p1_ff, p2_ff, p1_in, p2_in;
   logic signed [Q_W-1:0]    q_ff, q_in;
   logic signed [D_W-1:0]    d1, d2;
   logic signed [WW:0]       w1s, w2s;
   logic signed [PROD_W-1:0] prod1_ff, prod2_ff, prod1_in, prod2_in;
   logic signed [B_W-1:0]    base_ff, base_in;
   logic signed [ACC_W-1:0]  acc;
   logic signed [AR_W-1:0]   corner_rnd;
   logic signed [DW-1:0]     corner_in;
   logic                     corner_sat;
   logic signed [DW-1:0]     corner_ff;
   logic                     rsp_sat_ff;

   // effective width and row wrap
   logic [WC_W-1:0] width_ext, width_eff, col_next;
   logic            row_wrap;

   assign width_ext = WC_W'(row_width_ff);
   always_comb begin
      if (width_ext < WC_W'(2)) begin
         width_eff = WC_W'(2);
      end else if (width_ext > WC_W'(MAX_ROW)) begin
         width_eff = WC_W'(MAX_ROW);
      end else begin
         width_eff = width_ext;
      end
   end
   assign col_next = WC_W'(col_item_ff) + WC_W'(1);
   assign row_wrap = col_next >= width_eff;

   // accept: start of plane restarts the raster position
   assign rd_addr   = req_start_of_plane ? '0 : col_ff;
   assign item_emit = (rd_addr != '0) && !req_start_of_plane && past_ff;
   assign w1_in     = (req_weight1 > cemf_pkg::WEIGHT_ONE) ? cemf_pkg::WEIGHT_ONE : req_weight1;
   assign w2_in     = (req_weight2 > cemf_pkg::WEIGHT_ONE) ? cemf_pkg::WEIGHT_ONE : req_weight2;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= cemf_pkg::ROW_WIDTH_RESET;
         col_ff       <= '0;
         past_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) row_width_ff <= csr_wr_data;
         if (cmd.accept && req_start_of_plane) begin
            col_ff  <= '0;
            past_ff <= 1'b0;
         end else if (cmd.weight) begin
            if (row_wrap) begin
               col_ff  <= '0;
               past_ff <= 1'b1;
            end else begin
               col_ff <= col_next[COL_W-1:0];
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // neighbours reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         left_centre_ff <= '0;
         left_face2_ff  <= '0;
         upper_left_ff  <= '0;
      end else if (cmd.weight) begin
         left_centre_ff <= cc_ff;
         left_face2_ff  <= f2_ff;
         upper_left_ff  <= up_rd;
      end
   end

   // line buffer: read at accept, write back once the centred E3 is known
   always_ff @(posedge clock) begin
      if (cmd.accept) line_rd_ff <= line_mem[rd_addr];
      if (cmd.weight) line_mem[col_item_ff] <= {cc_ff, f1_ff};
   end

   assign up_rd  = line_rd_ff[2*DW-1:DW];
   assign f1u_rd = line_rd_ff[DW-1:0];

   // centred products
   assign pa_in = vx_ff * b2_ff;
   assign pb_in = vy_ff * b1_ff;

   // centred E3, rounded half up
   assign centre_sum = CW'(pa_ff) - CW'(pb_ff) + CW'(32768);
   assign centre_rnd = centre_sum[CW-1:16];
   always_comb begin
      cc_sat = 1'b0;
      cc_in  = centre_rnd[DW-1:0];
      if (centre_rnd > CR_W'(DATA_MAX)) begin
         cc_sat = 1'b1;
         cc_in  = DATA_MAX;
      end else if (centre_rnd < CR_W'(DATA_MIN)) begin
         cc_sat = 1'b1;
         cc_in  = DATA_MIN;
      end
   end

   // weight differences and unit-weight sum, all but the centred term
   assign p2_in = (P_W'(left_face2_ff) <<< 1) - P_W'(upper_left_ff) - P_W'(left_centre_ff)
                - (P_W'(f2_ff) <<< 1) + P_W'(up_rd);
   assign p1_in = (P_W'(f1u_rd) <<< 1) - P_W'(upper_left_ff) - P_W'(up_rd)
                - (P_W'(f1_ff) <<< 1) + P_W'(left_centre_ff);
   assign q_in  = (Q_W'(f2_ff) <<< 1) + Q_W'(f2_ff) + Q_W'(f1_ff) + Q_W'(left_face2_ff)
                - Q_W'(f1u_rd) - Q_W'(up_rd) - Q_W'(left_centre_ff);

   // weighted products
   assign d2       = D_W'(p2_ff) + D_W'(cc_ff);
   assign d1       = D_W'(p1_ff) + D_W'(cc_ff);
   assign w2s      = signed'({1'b0, w2_ff});
   assign w1s      = signed'({1'b0, w1_ff});
   assign prod2_in = w2s * d2;
   assign prod1_in = w1s * d1;
   assign base_in  = B_W'(q_ff) - (B_W'(cc_ff) <<< 1);

   // corner sum: quarter and weight scale, rounded half up
   assign acc = ACC_W'(prod1_ff) + ACC_W'(prod2_ff) + (ACC_W'(base_ff) <<< 16)
              + ACC_W'(131072);
   assign corner_rnd = acc[ACC_W-1:18];
   always_comb begin
      corner_sat = 1'b0;
      corner_in  = corner_rnd[DW-1:0];
      if (corner_rnd > AR_W'(DATA_MAX)) begin
         corner_sat = 1'b1;
         corner_in  = DATA_MAX;
      end else if (corner_rnd < AR_W'(DATA_MIN)) begin
         corner_sat = 1'b1;
         corner_in  = DATA_MIN;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         vx_ff       <= req_velocity_x;
         vy_ff       <= req_velocity_y;
         b1_ff       <= req_field_b1;
         b2_ff       <= req_field_b2;
         f1_ff       <= req_face1_e3;
         f2_ff       <= req_face2_e3;
         w1_ff       <= w1_in;
         w2_ff       <= w2_in;
         sat_ff      <= (req_weight1 > cemf_pkg::WEIGHT_ONE)
                     || (req_weight2 > cemf_pkg::WEIGHT_ONE);
         emit_ff     <= item_emit;
         col_item_ff <= rd_addr;
      end else if (cmd.centre) begin
         sat_ff <= sat_ff | cc_sat;
      end
      if (cmd.mul) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (cmd.centre) begin
         cc_ff <= cc_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         q_ff  <= q_in;
      end
      if (cmd.weight) begin
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
         base_ff  <= base_in;
      end
      if (cmd.out_load) begin
         corner_ff  <= corner_in;
         rsp_sat_ff <= sat_ff | corner_sat;
      end
   end

   assign status.emit     = emit_ff;
   assign status.out_full = rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corner_e3 = corner_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
`default_nettype wire

@@ rtl/corner_emf_stencil_2d_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// corner_emf_stencil_2d_top
// Corner E3 from a raster-ordered stream of 2D cells, upwind weighted.
//
// Use: cells enter on the req_ channel in raster order, one item per cell,
// with req_start_of_plane high on the first cell of each plane. Each cell
// whose left and upper neighbours exist yields one item on the rsp_ channel;
// cells in column 0 or the first row of a plane yield none but are stored.
// csr_wr_en writes the row width (ghost column included) and must only be used
// while the block is idle, which the block itself does not enforce. Widths
// below 2 act as 2, above MAX_ROW as MAX_ROW. Each item passes through the
// controller's four steps (centred products, centred E3, weighted products,
// corner sum), its result, if any, loaded into the output register in the
// last; a new item is taken only while idle or in the last step of the one
// before. The line buffer is read once and written once per item.
// Stall: the result waits in the output register while the next item is
// already taken and worked on; only its final step holds for a free register.
// Reset: row width 1024, column 0, first row, neighbour values zero. The line
// buffer is not cleared; only what was written in the plane reaches a result.
// ----------------------------------------------------------------------------
module corner_emf_stencil_2d_top #(
   parameter int MAX_ROW = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_wr_en,
   input  wire logic        [cemf_pkg::ROW_W-1:0]     csr_wr_data,
   // cell items
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_start_of_plane,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_velocity_x,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_velocity_y,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_field_b1,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_field_b2,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_face1_e3,
   input  wire logic signed [cemf_pkg::DATA_W-1:0]    req_face2_e3,
   input  wire logic        [cemf_pkg::WEIGHT_W-1:0]  req_weight1,
   input  wire logic        [cemf_pkg::WEIGHT_W-1:0]  req_weight2,
   // corner items
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed      [cemf_pkg::DATA_W-1:0]    rsp_corner_e3,
   output logic                                       rsp_saturated
);

   cemf_pkg::dp_cmd_type    cmd;
   cemf_pkg::dp_status_type status;

   // sequence each item through its four steps
   cemf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, line buffer and output register
   cemf_dp #(
      .MAX_ROW (MAX_ROW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_start_of_plane (req_start_of_plane),
      .req_velocity_x     (req_velocity_x),
      .req_velocity_y     (req_velocity_y),
      .req_field_b1       (req_field_b1),
      .req_field_b2       (req_field_b2),
      .req_face1_e3       (req_face1_e3),
      .req_face2_e3       (req_face2_e3),
      .req_weight1        (req_weight1),
      .req_weight2        (req_weight2),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_corner_e3      (rsp_corner_e3),
      .rsp_saturated      (rsp_saturated)
   );

endmodule
`default_nettype wire
